// ===== rtl/core/tfn_pkg.sv =====
// tfn_pkg: shared types and constants for the triangle face normal core.
// No dependencies.
package tfn_pkg;
   localparam int EDGE_W  = 16;
   localparam int CROSS_W = 32;
   localparam int MAG_W   = 31;
   localparam int SUM_W   = 64;
   localparam int LEN_W   = 32;
   localparam int Q_W     = 16;
   localparam logic [Q_W-1:0] NORM_ONE = 16'd16384;

   // leading-one position (0 when zero) of a 64 bit word
   function automatic logic [5:0] msb64(input logic [63:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++)
         if (v[i]) p = 6'(i);
      return p;
   endfunction
endpackage

// ===== rtl/core/triangle_face_normal_core.sv =====
// triangle_face_normal_core: unit face normal of a triangle, Q16.16 in, Q2.14 out.
// Stages in order: edges, cross, scale, squares, sqrt, divide and an output register.
// Throughput one word per cycle; the whole pipe advances together and holds when the
// output register is full and not taken.
// Reset (synchronous, active high) clears the valid bits only.
// Depends on tfn_pkg, tfn_edge, tfn_sqrt, tfn_div.
module triangle_face_normal_core import tfn_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z (lowest first)
   input  logic [9*COORD_WIDTH-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // normal_x, normal_y, normal_z, degenerate, zero pad (lowest first)
   output logic [55:0]              rsp_tdata
);
   localparam int CW = COORD_WIDTH;
   localparam int PRE = 6;               // stages ahead of the sqrt
   localparam int SQ  = LEN_W;
   localparam int DV  = 16;
   localparam int TOT = PRE + SQ + DV;

   // one global enable: pipe advances unless the output word is held
   logic adv;
   logic [TOT-1:0] vld_ff;
   logic out_v_ff;
   logic [55:0] out_d_ff;

   assign adv = !out_v_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         vld_ff   <= {vld_ff[TOT-2:0], req_tvalid};
         out_v_ff <= vld_ff[TOT-1];
      end
   end

   logic [CW-1:0] p [9];
   for (genvar g = 0; g < 9; g++) begin : g_unp
      assign p[g] = req_tdata[g*CW +: CW];
   end

   // stages 1-2: edge reduction
   logic signed [EDGE_W-1:0] a [3], b [3];
   tfn_edge #(.COORD_WIDTH(CW)) u_e1 (.clock, .en(adv),
      .to_x(p[3]), .to_y(p[4]), .to_z(p[5]), .fr_x(p[0]), .fr_y(p[1]), .fr_z(p[2]),
      .e_ff(a));
   tfn_edge #(.COORD_WIDTH(CW)) u_e2 (.clock, .en(adv),
      .to_x(p[6]), .to_y(p[7]), .to_z(p[8]), .fr_x(p[0]), .fr_y(p[1]), .fr_z(p[2]),
      .e_ff(b));

   // stage 3: six products; stage 4: differences, sign and magnitude
   logic signed [CROSS_W-1:0] pr_ff [6];
   logic [MAG_W-1:0] m4_ff [3];
   logic             n4_ff [3];
   logic signed [CROSS_W:0] c;
   always_ff @(posedge clock) begin
      if (adv) begin
         pr_ff[0] <= a[1] * b[2];  pr_ff[1] <= a[2] * b[1];
         pr_ff[2] <= a[2] * b[0];  pr_ff[3] <= a[0] * b[2];
         pr_ff[4] <= a[0] * b[1];  pr_ff[5] <= a[1] * b[0];
      end
   end
   logic [MAG_W-1:0] m4_in [3];
   logic             n4_in [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c = (CROSS_W+1)'(pr_ff[2*k]) - (CROSS_W+1)'(pr_ff[2*k+1]);
         n4_in[k] = c[CROSS_W];
         m4_in[k] = c[CROSS_W] ? MAG_W'(-c) : MAG_W'(c);
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         m4_ff <= m4_in;
         n4_ff <= n4_in;
      end
   end

   // stage 5: normalise so the largest magnitude has bit 30 set
   logic [MAG_W-1:0] m5_ff [3], m5_in [3];
   logic [2:0] n5_ff;
   logic       dg5_ff;
   logic [MAG_W-1:0] mor;
   logic [5:0] sh;
   always_comb begin
      mor = m4_ff[0] | m4_ff[1] | m4_ff[2];
      sh  = 6'(MAG_W - 1) - msb64(64'(mor));
      for (int k = 0; k < 3; k++) m5_in[k] = m4_ff[k] << sh;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         m5_ff  <= m5_in;
         n5_ff  <= {n4_ff[2], n4_ff[1], n4_ff[0]};
         dg5_ff <= (mor == '0);
      end
   end

   // stage 6: squares and sum
   logic [SUM_W-1:0] sum_ff;
   logic [3*MAG_W-1:0] m6_ff;
   logic [2:0] n6_ff;
   logic       dg6_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= SUM_W'(m5_ff[0] * m5_ff[0]) + SUM_W'(m5_ff[1] * m5_ff[1])
                 + SUM_W'(m5_ff[2] * m5_ff[2]);
         m6_ff  <= {m5_ff[2], m5_ff[1], m5_ff[0]};
         n6_ff  <= n5_ff;
         dg6_ff <= dg5_ff;
      end
   end

   // square root, carrying magnitudes and signs alongside
   localparam int SW = 3*MAG_W + 4;
   logic [LEN_W-1:0] len;
   logic [SW-1:0] sd;
   tfn_sqrt #(.SIDE_W(SW)) u_sqrt (.clock, .en(adv), .x(sum_ff),
      .side({dg6_ff, n6_ff, m6_ff}), .root(len), .side_out(sd));

   // three dividers; sign and flag ride a matching delay line
   logic [Q_W-1:0] q [3];
   for (genvar g = 0; g < 3; g++) begin : g_div
      tfn_div u_div (.clock, .en(adv), .mag(sd[g*MAG_W +: MAG_W]),
         .len((len == '0) ? LEN_W'(1) : len), .q(q[g]));
   end
   logic [3:0] fl_ff [DV];
   always_ff @(posedge clock) begin
      if (adv) begin
         fl_ff[0] <= sd[SW-1:3*MAG_W];
         for (int i = 1; i < DV; i++) fl_ff[i] <= fl_ff[i-1];
      end
   end

   // output register
   logic [Q_W-1:0] r [3];
   logic dgo;
   always_comb begin
      dgo = fl_ff[DV-1][3];
      for (int k = 0; k < 3; k++)
         r[k] = dgo ? '0 : (fl_ff[DV-1][k] ? Q_W'(-q[k]) : q[k]);
   end
   always_ff @(posedge clock) begin
      if (adv) out_d_ff <= {7'd0, dgo, r[2], r[1], r[0]};
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
endmodule

// ===== rtl/core/tfn_edge.sv =====
// tfn_edge: edge difference and power-of-two reduction to 16 bits, two stages.
// Depends on tfn_pkg.
module tfn_edge import tfn_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [COORD_WIDTH-1:0] to_x, to_y, to_z,
   input  logic [COORD_WIDTH-1:0] fr_x, fr_y, fr_z,
   output logic signed [EDGE_W-1:0] e_ff [3]
);
   localparam int DW = COORD_WIDTH + 1;
   logic [DW-1:0] mag_ff [3], mag_in [3];
   logic          neg_ff [3], neg_in [3];
   logic [COORD_WIDTH-1:0] tv [3], fv [3];
   logic signed [EDGE_W-1:0] e_in [3];
   logic [DW-1:0] maxm;
   logic [5:0]    s;
   logic signed [DW-1:0] d;

   assign tv = '{to_x, to_y, to_z};
   assign fv = '{fr_x, fr_y, fr_z};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d = DW'(signed'(tv[k])) - DW'(signed'(fv[k]));
         neg_in[k] = d[DW-1];
         mag_in[k] = d[DW-1] ? DW'(-d) : DW'(d);
      end
   end

   always_comb begin
      maxm = mag_ff[0] | mag_ff[1] | mag_ff[2];
      // msb of OR equals msb of max; shift so result fits 15 bits
      s = (msb64(64'(maxm)) >= 6'd15 && maxm != '0) ? 6'(msb64(64'(maxm)) - 6'd14) : 6'd0;
      for (int k = 0; k < 3; k++) begin
         e_in[k] = neg_ff[k] ? -EDGE_W'(mag_ff[k] >> s) : EDGE_W'(mag_ff[k] >> s);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         e_ff   <= e_in;
      end
   end
endmodule

// ===== rtl/core/tfn_sqrt.sv =====
// tfn_sqrt: pipelined restoring integer square root, one result bit per stage.
// Depends on tfn_pkg.
module tfn_sqrt import tfn_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [SUM_W-1:0]  x,
   input  logic [SIDE_W-1:0] side,
   output logic [LEN_W-1:0]  root,
   output logic [SIDE_W-1:0] side_out
);
   localparam int N = LEN_W;
   logic [SUM_W-1:0]  rem_ff [N];
   logic [LEN_W-1:0]  res_ff [N];
   logic [SIDE_W-1:0] sd_ff  [N];

   for (genvar g = 0; g < N; g++) begin : g_st
      logic [SUM_W-1:0]  rem_cur, rem_in;
      logic [LEN_W-1:0]  res_cur, res_in;
      logic [SIDE_W-1:0] sd_cur;
      logic [SUM_W+1:0]  trial;

      if (g == 0) begin : g_first
         assign rem_cur = x;
         assign res_cur = '0;
         assign sd_cur  = side;
      end else begin : g_next
         assign rem_cur = rem_ff[g-1];
         assign res_cur = res_ff[g-1];
         assign sd_cur  = sd_ff[g-1];
      end

      always_comb begin
         // bit N-1-g; trial = (res<<2 | 1) << (2*(N-1-g))
         trial = (SUM_W+2)'({res_cur, 2'b01}) << (2 * (N - 1 - g));
         if ((SUM_W+2)'(rem_cur) >= trial) begin
            rem_in = SUM_W'((SUM_W+2)'(rem_cur) - trial);
            res_in = {res_cur[LEN_W-2:0], 1'b1};
         end else begin
            rem_in = rem_cur;
            res_in = {res_cur[LEN_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= rem_in;
            res_ff[g] <= res_in;
            sd_ff[g]  <= sd_cur;
         end
      end
   end

   assign root     = res_ff[N-1];
   assign side_out = sd_ff[N-1];
endmodule

// ===== rtl/core/tfn_div.sv =====
// tfn_div: pipelined restoring divider, (mag<<14 + len/2) / len, clamped.
// Depends on tfn_pkg.
module tfn_div import tfn_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [MAG_W-1:0] mag,
   input  logic [LEN_W-1:0] len,
   output logic [Q_W-1:0]   q
);
   // quotient fits 15 bits unclamped headroom to 16: compute 16 bits
   localparam int NB = 16;
   localparam int NW = MAG_W + 14 + 1;
   logic [NW-1:0]    num_ff [NB];
   logic [LEN_W-1:0] den_ff [NB];
   logic [NB-1:0]    qt_ff  [NB];
   logic [NB:0]      qbig;

   for (genvar g = 0; g < NB; g++) begin : g_st
      logic [NW-1:0]    num_cur, num_in;
      logic [LEN_W-1:0] den_cur;
      logic [NB-1:0]    qt_cur, qt_in;
      logic [NW+NB-1:0] t;

      if (g == 0) begin : g_first
         assign num_cur = NW'({mag, 14'd0}) + NW'(len >> 1);
         assign den_cur = len;
         assign qt_cur  = '0;
      end else begin : g_next
         assign num_cur = num_ff[g-1];
         assign den_cur = den_ff[g-1];
         assign qt_cur  = qt_ff[g-1];
      end

      always_comb begin
         t = (NW+NB)'(den_cur) << (NB - 1 - g);
         if ((NW+NB)'(num_cur) >= t) begin
            num_in = NW'((NW+NB)'(num_cur) - t);
            qt_in  = {qt_cur[NB-2:0], 1'b1};
         end else begin
            num_in = num_cur;
            qt_in  = {qt_cur[NB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[g] <= num_in;
            den_ff[g] <= den_cur;
            qt_ff[g]  <= qt_in;
         end
      end
   end

   // |c|<=len so quotient never exceeds 2^14+1; the top trial bit suffices
   assign qbig = {1'b0, qt_ff[NB-1]};
   assign q = (qbig > (NB+1)'(NORM_ONE)) ? NORM_ONE : qt_ff[NB-1];
endmodule
